### src/dplp_pkg.sv
// Shared types, character codes and arithmetic helpers of the decimal pair line parser.
package dplp_pkg;

  // Kept fraction digits of each number; values are in units of 10^-FRAC_DIGITS.
  localparam int unsigned FRAC_DIGITS = 3;
  // Default line buffer capacity; at most LINE_CAPACITY-1 characters fit.
  localparam int unsigned LINE_CAPACITY = 160;

  localparam logic [30:0] SAT_MAX = '1;

  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_UP_B  = 8'h42;
  localparam logic [7:0] CH_UP_P  = 8'h50;
  localparam logic [7:0] CH_LO_E  = 8'h65;
  localparam logic [7:0] CH_LO_N  = 8'h6E;
  localparam logic [7:0] CH_LO_O  = 8'h6F;
  localparam logic [7:0] CH_NUL   = 8'h00;

  // Position inside a number field (low two bits of a number phase).
  localparam logic [1:0] OFF_LEAD  = 2'd0;
  localparam logic [1:0] OFF_INT   = 2'd1;
  localparam logic [1:0] OFF_FRAC  = 2'd2;
  localparam logic [1:0] OFF_TRAIL = 2'd3;

  typedef enum logic [3:0] {
    PH_START        = 4'd0,
    PH_N1           = 4'd1,
    PH_N2           = 4'd2,
    PH_N3           = 4'd3,
    PH_NONE         = 4'd4,
    PH_TUNE         = 4'd5,
    PH_BAD          = 4'd6,
    PH_B            = 4'd7,
    PH_FIRST_LEAD   = 4'd8,
    PH_FIRST_INT    = 4'd9,
    PH_FIRST_FRAC   = 4'd10,
    PH_FIRST_TRAIL  = 4'd11,
    PH_SECOND_LEAD  = 4'd12,
    PH_SECOND_INT   = 4'd13,
    PH_SECOND_FRAC  = 4'd14,
    PH_SECOND_TRAIL = 4'd15
  } phase_t;

  typedef enum logic [2:0] {
    KIND_NO_BALL   = 3'd0,
    KIND_BALL      = 3'd1,
    KIND_TUNING    = 3'd2,
    KIND_MALFORMED = 3'd3,
    KIND_OVERFLOW  = 3'd4
  } kind_t;

  function automatic logic [9:0] pow_ten(logic [1:0] idx);
    logic [9:0] p;
    unique case (idx)
      2'd0: p = 10'd1;
      2'd1: p = 10'd10;
      2'd2: p = 10'd100;
      default: p = 10'd1000;
    endcase
    return p;
  endfunction

  // acc*10 + d, saturated.
  function automatic logic [30:0] push_digit(logic [30:0] acc, logic [3:0] d);
    logic [34:0] t;
    t = (35'(acc) << 3) + (35'(acc) << 1) + 35'(d);
    return (t > 35'(SAT_MAX)) ? SAT_MAX : t[30:0];
  endfunction

  // Scale kept digits up to full thousandths, saturate, apply sign.
  function automatic logic [31:0] scale_value(logic [30:0] acc, logic [1:0] frac_seen,
                                              logic neg);
    logic [40:0] mag;
    logic [30:0] m;
    mag = 41'(acc) * 41'(pow_ten(2'(FRAC_DIGITS) - frac_seen));
    m = (mag > 41'(SAT_MAX)) ? SAT_MAX : mag[30:0];
    return neg ? (32'd0 - {1'b0, m}) : {1'b0, m};
  endfunction

endpackage

### src/decimal_pair_line_parser.sv
// Top level of the decimal pair line parser: byte register, line parse state, result register.
//
// Usage: bytes arrive on in_rx_byte with in_valid/in_ready. While the stream
// is enabled, each newline-terminated line ("none", "B,<num>,<num>", a tuning
// line starting with 'P', or anything else) produces one result item on the
// out_ channel: line kind, the two numbers in signed thousandths (zero unless
// a ball measurement) and the running parse error count. Carriage returns are
// dropped, as is every byte while disabled. A line that grows past
// LINE_CAPACITY-1 characters yields an overflow item and restarts.
// cfg_stream_enable is written over cfg_valid/cfg_ready while the block is
// idle; every write clears the partial line and keeps the error count.
// A byte accepted into the byte register is parsed combinationally from it, and the
// result item that it completes is loaded into the result register. Throughput: one
// byte per cycle while the receiver does not stall, set by the single parse step
// between the byte register and the result register. When the receiver
// stalls, the result register holds its item, the byte register holds its
// byte and in_ready drops until the result is taken.
// Reset (synchronous, rst_n low) disables the stream, clears the line state
// and the error count and empties both registers.
module decimal_pair_line_parser #(
  parameter int unsigned LINE_CAPACITY = dplp_pkg::LINE_CAPACITY
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_rx_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  out_line_kind,
  output logic signed [31:0] out_ball_offset,
  output logic signed [31:0] out_ball_velocity,
  output logic [31:0] out_parse_errors,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_stream_enable
);

  localparam int unsigned CNT_W = $clog2(LINE_CAPACITY);
  localparam logic [CNT_W-1:0] CNT_LIMIT = CNT_W'(LINE_CAPACITY - 1);

  // byte register
  logic             in_vld_r;
  logic [7:0]       in_byte_r;

  // line parse state
  logic             stream_enable_r, stream_enable_nxt;
  logic [CNT_W-1:0] char_count_r, char_count_nxt;
  dplp_pkg::phase_t phase_r, phase_nxt;
  logic [30:0]      accum_r, accum_nxt;
  logic [1:0]       frac_r, frac_nxt;
  logic             neg_r, neg_nxt;
  logic             digit_seen_r, digit_seen_nxt;
  logic [31:0]      first_value_r, first_value_nxt;
  logic             content_ended_r, content_ended_nxt;
  logic [31:0]      error_total_r, error_total_nxt;

  // result register
  logic             out_vld_r;
  dplp_pkg::kind_t  out_kind_r;
  logic [31:0]      out_pos_r, out_vel_r, out_err_r;

  logic             proc;
  logic             cfg_wr;
  logic             load_out;
  logic             restart;
  logic             chk_comma;
  dplp_pkg::kind_t  kind;
  logic [31:0]      pos, vel;
  logic [31:0]      fin;
  logic [7:0]       c;
  logic             is_blank, is_digit, is_comma, second;
  logic [1:0]       off;

  // Parse the held byte whenever the result register can take a result.
  assign proc      = in_vld_r && (!out_vld_r || out_ready);
  assign in_ready  = !in_vld_r || proc;
  assign cfg_ready = !in_vld_r;
  assign cfg_wr    = cfg_valid && cfg_ready;

  assign c        = in_byte_r;
  assign is_blank = (c == dplp_pkg::CH_SPACE) || (c == dplp_pkg::CH_TAB);
  assign is_digit = (c >= dplp_pkg::CH_ZERO) && (c <= dplp_pkg::CH_NINE);
  assign second   = phase_r[2];
  assign is_comma = (c == dplp_pkg::CH_COMMA) && !second;
  assign off      = phase_r[1:0];
  assign fin      = dplp_pkg::scale_value(accum_r, frac_r, neg_r);

  always_comb begin
    stream_enable_nxt = stream_enable_r;
    char_count_nxt    = char_count_r;
    phase_nxt         = phase_r;
    accum_nxt         = accum_r;
    frac_nxt          = frac_r;
    neg_nxt           = neg_r;
    digit_seen_nxt    = digit_seen_r;
    first_value_nxt   = first_value_r;
    content_ended_nxt = content_ended_r;
    error_total_nxt   = error_total_r;
    load_out          = 1'b0;
    restart           = 1'b0;
    chk_comma         = 1'b0;
    kind              = dplp_pkg::KIND_NO_BALL;
    pos               = 32'd0;
    vel               = 32'd0;

    if (cfg_wr) begin
      stream_enable_nxt = cfg_stream_enable;
      restart           = 1'b1;
    end else if (proc && stream_enable_r && (c != dplp_pkg::CH_CR)) begin
      if (c == dplp_pkg::CH_LF) begin
        // End of line: classify and restart.
        load_out = 1'b1;
        restart  = 1'b1;
        if (phase_r == dplp_pkg::PH_NONE) begin
          kind = dplp_pkg::KIND_NO_BALL;
        end else if (phase_r == dplp_pkg::PH_TUNE) begin
          kind = dplp_pkg::KIND_TUNING;
        end else if (digit_seen_r && ((phase_r == dplp_pkg::PH_SECOND_INT) ||
                                      (phase_r == dplp_pkg::PH_SECOND_FRAC) ||
                                      (phase_r == dplp_pkg::PH_SECOND_TRAIL))) begin
          kind = dplp_pkg::KIND_BALL;
          pos  = first_value_r;
          vel  = fin;
        end else begin
          kind            = dplp_pkg::KIND_MALFORMED;
          error_total_nxt = error_total_r + 32'd1;
        end
      end else if (char_count_r < CNT_LIMIT) begin
        char_count_nxt = char_count_r + CNT_W'(1);
        if (!content_ended_r) begin
          if (c == dplp_pkg::CH_NUL) begin
            content_ended_nxt = 1'b1;
          end else begin
            unique case (phase_r)
              dplp_pkg::PH_START: begin
                if (c == dplp_pkg::CH_LO_N) begin
                  phase_nxt = dplp_pkg::PH_N1;
                end else if (c == dplp_pkg::CH_UP_P) begin
                  phase_nxt = dplp_pkg::PH_TUNE;
                end else if (c == dplp_pkg::CH_UP_B) begin
                  phase_nxt = dplp_pkg::PH_B;
                end else begin
                  phase_nxt = dplp_pkg::PH_BAD;
                end
              end
              dplp_pkg::PH_N1: begin
                phase_nxt = (c == dplp_pkg::CH_LO_O) ? dplp_pkg::PH_N2 : dplp_pkg::PH_BAD;
              end
              dplp_pkg::PH_N2: begin
                phase_nxt = (c == dplp_pkg::CH_LO_N) ? dplp_pkg::PH_N3 : dplp_pkg::PH_BAD;
              end
              dplp_pkg::PH_N3: begin
                phase_nxt = (c == dplp_pkg::CH_LO_E) ? dplp_pkg::PH_NONE : dplp_pkg::PH_BAD;
              end
              dplp_pkg::PH_TUNE: begin
                phase_nxt = dplp_pkg::PH_TUNE;
              end
              dplp_pkg::PH_B: begin
                phase_nxt = (c == dplp_pkg::CH_COMMA) ? dplp_pkg::PH_FIRST_LEAD
                                                      : dplp_pkg::PH_BAD;
              end
              dplp_pkg::PH_FIRST_LEAD, dplp_pkg::PH_FIRST_INT,
              dplp_pkg::PH_FIRST_FRAC, dplp_pkg::PH_FIRST_TRAIL,
              dplp_pkg::PH_SECOND_LEAD, dplp_pkg::PH_SECOND_INT,
              dplp_pkg::PH_SECOND_FRAC, dplp_pkg::PH_SECOND_TRAIL: begin
                if (off == dplp_pkg::OFF_LEAD) begin
                  // Leading blanks, then sign, digit or point.
                  if (is_blank) begin
                    phase_nxt = phase_r;
                  end else if (c == dplp_pkg::CH_MINUS) begin
                    neg_nxt   = 1'b1;
                    phase_nxt = dplp_pkg::phase_t'({1'b1, second, dplp_pkg::OFF_INT});
                  end else if (c == dplp_pkg::CH_PLUS) begin
                    phase_nxt = dplp_pkg::phase_t'({1'b1, second, dplp_pkg::OFF_INT});
                  end else if (is_digit) begin
                    digit_seen_nxt = 1'b1;
                    accum_nxt      = dplp_pkg::push_digit(accum_r, c[3:0]);
                    phase_nxt      = dplp_pkg::phase_t'({1'b1, second, dplp_pkg::OFF_INT});
                  end else if (c == dplp_pkg::CH_DOT) begin
                    phase_nxt = dplp_pkg::phase_t'({1'b1, second, dplp_pkg::OFF_FRAC});
                  end else begin
                    phase_nxt = dplp_pkg::PH_BAD;
                  end
                end else if (off == dplp_pkg::OFF_TRAIL) begin
                  if (is_blank) begin
                    phase_nxt = phase_r;
                  end else begin
                    chk_comma = 1'b1;
                  end
                end else begin
                  if (is_digit) begin
                    digit_seen_nxt = 1'b1;
                    if (off == dplp_pkg::OFF_INT) begin
                      accum_nxt = dplp_pkg::push_digit(accum_r, c[3:0]);
                    end else if (frac_r < 2'(dplp_pkg::FRAC_DIGITS)) begin
                      // Drop fraction digits beyond the kept precision.
                      accum_nxt = dplp_pkg::push_digit(accum_r, c[3:0]);
                      frac_nxt  = frac_r + 2'd1;
                    end
                  end else if ((c == dplp_pkg::CH_DOT) && (off == dplp_pkg::OFF_INT)) begin
                    phase_nxt = dplp_pkg::phase_t'({1'b1, second, dplp_pkg::OFF_FRAC});
                  end else if (is_blank) begin
                    phase_nxt = digit_seen_r
                              ? dplp_pkg::phase_t'({1'b1, second, dplp_pkg::OFF_TRAIL})
                              : dplp_pkg::PH_BAD;
                  end else begin
                    chk_comma = 1'b1;
                  end
                end
                if (chk_comma) begin
                  if (is_comma && digit_seen_r) begin
                    // First number done: latch it and start the second.
                    first_value_nxt = fin;
                    accum_nxt       = 31'd0;
                    frac_nxt        = 2'd0;
                    neg_nxt         = 1'b0;
                    digit_seen_nxt  = 1'b0;
                    phase_nxt       = dplp_pkg::PH_SECOND_LEAD;
                  end else begin
                    phase_nxt = dplp_pkg::PH_BAD;
                  end
                end
              end
              default: begin
                phase_nxt = dplp_pkg::PH_BAD;
              end
            endcase
          end
        end
      end else begin
        // Line too long: drop the byte, report overflow, restart.
        load_out        = 1'b1;
        restart         = 1'b1;
        kind            = dplp_pkg::KIND_OVERFLOW;
        error_total_nxt = error_total_r + 32'd1;
      end
    end

    if (restart) begin
      char_count_nxt    = '0;
      phase_nxt         = dplp_pkg::PH_START;
      accum_nxt         = 31'd0;
      frac_nxt          = 2'd0;
      neg_nxt           = 1'b0;
      digit_seen_nxt    = 1'b0;
      first_value_nxt   = 32'd0;
      content_ended_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r        <= 1'b0;
      out_vld_r       <= 1'b0;
      stream_enable_r <= 1'b0;
      char_count_r    <= '0;
      phase_r         <= dplp_pkg::PH_START;
      accum_r         <= 31'd0;
      frac_r          <= 2'd0;
      neg_r           <= 1'b0;
      digit_seen_r    <= 1'b0;
      first_value_r   <= 32'd0;
      content_ended_r <= 1'b0;
      error_total_r   <= 32'd0;
    end else begin
      if (in_ready) begin
        in_vld_r <= in_valid;
      end
      if (load_out) begin
        out_vld_r <= 1'b1;
      end else if (out_ready) begin
        out_vld_r <= 1'b0;
      end
      stream_enable_r <= stream_enable_nxt;
      char_count_r    <= char_count_nxt;
      phase_r         <= phase_nxt;
      accum_r         <= accum_nxt;
      frac_r          <= frac_nxt;
      neg_r           <= neg_nxt;
      digit_seen_r    <= digit_seen_nxt;
      first_value_r   <= first_value_nxt;
      content_ended_r <= content_ended_nxt;
      error_total_r   <= error_total_nxt;
    end
  end

  // Payload registers: no reset needed.
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_byte_r <= in_rx_byte;
    end
    if (load_out) begin
      out_kind_r <= kind;
      out_pos_r  <= pos;
      out_vel_r  <= vel;
      out_err_r  <= error_total_nxt;
    end
  end

  assign out_valid          = out_vld_r;
  assign out_line_kind      = out_kind_r;
  assign out_ball_offset    = out_pos_r;
  assign out_ball_velocity  = out_vel_r;
  assign out_parse_errors   = out_err_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    char_count_r <= CNT_LIMIT)
    else $error("line character count exceeds capacity");

  a_err_step: assert property (@(posedge clk) disable iff (!rst_n)
    (load_out && ((kind == dplp_pkg::KIND_MALFORMED) || (kind == dplp_pkg::KIND_OVERFLOW)))
    |=> (error_total_r == $past(error_total_r) + 32'd1))
    else $error("error count did not advance on a bad line");

  a_err_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !load_out |=> (error_total_r == $past(error_total_r)))
    else $error("error count changed without a result");

  a_zero_values: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && (out_kind_r != dplp_pkg::KIND_BALL))
    |-> ((out_pos_r == 32'd0) && (out_vel_r == 32'd0)))
    else $error("nonzero values on a result that is not a ball measurement");

  a_disabled_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (proc && !stream_enable_r) |-> !load_out)
    else $error("result produced while the stream is disabled");

endmodule
